FILE: design/aabb_frustum_cull_test_unit_macros.svh
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_unit_macros.svh
// Assertion helpers shared by the frustum cull test RTL.
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_TEST_UNIT_MACROS_SVH
`define AABB_FRUSTUM_CULL_TEST_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AFCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frustum cull unit: implication check failed");

// next-cycle implication, disabled during reset
`define AFCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frustum cull unit: next-cycle check failed");

`endif

FILE: design/afct_pkg.sv
// ----------------------------------------------------------------------------
// afct_pkg
// Types and constants of the AABB frustum cull test unit.
// ----------------------------------------------------------------------------
package afct_pkg;

  localparam int COORD_W   = 16;            // box coordinate width
  localparam int NRM_W     = 16;            // Q1.14 normal component width
  localparam int DIST_W    = 16;            // plane distance width
  localparam int FRAC_BITS = 14;            // normal fraction bits
  localparam int PROD_W    = NRM_W + COORD_W;
  localparam int SUM_W     = PROD_W + 2;    // three products plus distance term
  localparam int CFG_W     = 64;
  localparam int REG_COUNT = 6;             // plane registers
  localparam int CFG_IDX_W = 3;

  // plane register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_4 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_5 = 3'd5;

  // plane register layout, msb first
  typedef struct packed {
    logic signed [DIST_W-1:0] d;
    logic signed [NRM_W-1:0]  nz;
    logic signed [NRM_W-1:0]  ny;
    logic signed [NRM_W-1:0]  nx;
  } plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } box_req_t;

  typedef struct packed {
    logic visible;
    logic box_invalid;
  } cull_res_t;

  // what moves from cell to cell
  typedef struct packed {
    box_req_t box;
    logic     invalid;
    logic     culled;
  } cull_tok_t;

endpackage

FILE: design/afct_cell.sv
// ----------------------------------------------------------------------------
// afct_cell
// One plane of the cull chain: holds its plane register, picks the positive
// vertex, multiplies (stage A), sums and tests the sign (stage B).
// ----------------------------------------------------------------------------
module afct_cell #(
  parameter int PLANE_IDX = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [afct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afct_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  afct_pkg::cull_tok_t            up_tok,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output afct_pkg::cull_tok_t            dn_tok
);

  localparam bit HAS_REG = (PLANE_IDX < afct_pkg::REG_COUNT);

  afct_pkg::plane_t plane_r;

  logic                             a_v_r;
  afct_pkg::cull_tok_t              a_tok_r;
  logic signed [afct_pkg::PROD_W-1:0] a_px_r, a_py_r, a_pz_r;
  logic                             b_v_r;
  afct_pkg::cull_tok_t              b_tok_r;
  afct_pkg::cull_tok_t              b_tok_nxt;

  logic a_rdy, b_rdy;
  logic signed [afct_pkg::COORD_W-1:0] vx, vy, vz;
  logic signed [afct_pkg::PROD_W-1:0]  px_nxt, py_nxt, pz_nxt;
  logic signed [afct_pkg::SUM_W-1:0]   sum;

  // planes at or past the register count stay zero and never cull
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (HAS_REG && cfg_we &&
                 cfg_index == afct_pkg::CFG_IDX_W'(PLANE_IDX)) begin
      plane_r <= afct_pkg::plane_t'(cfg_wdata);
    end
  end

  assign b_rdy    = !b_v_r || dn_ready;
  assign a_rdy    = !a_v_r || b_rdy;
  assign up_ready = a_rdy;

  // positive vertex: max where the normal component is non-negative
  assign vx = plane_r.nx[afct_pkg::NRM_W-1] ? up_tok.box.min_x : up_tok.box.max_x;
  assign vy = plane_r.ny[afct_pkg::NRM_W-1] ? up_tok.box.min_y : up_tok.box.max_y;
  assign vz = plane_r.nz[afct_pkg::NRM_W-1] ? up_tok.box.min_z : up_tok.box.max_z;

  assign px_nxt = plane_r.nx * vx;
  assign py_nxt = plane_r.ny * vy;
  assign pz_nxt = plane_r.nz * vz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && up_valid) begin
      a_tok_r <= up_tok;
      a_px_r  <= px_nxt;
      a_py_r  <= py_nxt;
      a_pz_r  <= pz_nxt;
    end
  end

  assign sum = afct_pkg::SUM_W'(a_px_r) + afct_pkg::SUM_W'(a_py_r)
             + afct_pkg::SUM_W'(a_pz_r)
             + (afct_pkg::SUM_W'(plane_r.d) <<< afct_pkg::FRAC_BITS);

  always_comb begin
    b_tok_nxt        = a_tok_r;
    b_tok_nxt.culled = a_tok_r.culled | sum[afct_pkg::SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_rdy) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_v_r) begin
      b_tok_r <= b_tok_nxt;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_tok   = b_tok_r;

endmodule

FILE: design/aabb_frustum_cull_test_unit.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_unit
// Positive-vertex AABB frustum cull test, one box per cycle while out_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_req carries one box (min and max
//   corners). Output channel out_valid / out_stall / out_req returns one
//   result per box, in order: visible and box_invalid.
//   Planes are written through cfg_we / cfg_index / cfg_wdata while the unit
//   is idle; index 0..5 selects the plane, other indexes are ignored.
//   Each box passes one input stage plus a multiply stage and a sum/sign stage
//   in each plane cell of the chain.
//   Throughput is one box per cycle while out_stall is low; each plane cell
//   has its own three multipliers, so every cell works on a different box.
//   When out_stall is high the chain fills its bubbles and then raises
//   in_stall; results are held until taken.
//   Synchronous reset (rst_n low) empties the chain and clears all planes to
//   zero; a zero plane never culls.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test_unit #(
  parameter int NUM_PLANES = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [afct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afct_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  afct_pkg::box_req_t             in_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output afct_pkg::cull_res_t            out_req
);

  `include "aabb_frustum_cull_test_unit_macros.svh"

  logic                s0_v_r;
  afct_pkg::cull_tok_t s0_tok_r;
  afct_pkg::cull_tok_t s0_tok_nxt;

  logic                v   [NUM_PLANES+1];
  logic                rdy [NUM_PLANES+1];
  afct_pkg::cull_tok_t tok [NUM_PLANES+1];

  // input stage: register the box and flag min above max
  always_comb begin
    s0_tok_nxt         = '0;
    s0_tok_nxt.box     = in_req;
    s0_tok_nxt.invalid = (in_req.min_x > in_req.max_x) ||
                         (in_req.min_y > in_req.max_y) ||
                         (in_req.min_z > in_req.max_z);
    s0_tok_nxt.culled  = 1'b0;
  end

  assign in_stall = s0_v_r && !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (!in_stall) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_tok_r <= s0_tok_nxt;
    end
  end

  assign v[0]   = s0_v_r;
  assign tok[0] = s0_tok_r;

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
    afct_cell #(
      .PLANE_IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg_we    (cfg_we),
      .cfg_index (cfg_index),
      .cfg_wdata (cfg_wdata),
      .up_valid  (v[k]),
      .up_ready  (rdy[k]),
      .up_tok    (tok[k]),
      .dn_valid  (v[k+1]),
      .dn_ready  (rdy[k+1]),
      .dn_tok    (tok[k+1])
    );
  end

  assign rdy[NUM_PLANES]     = !out_stall;
  assign out_valid           = v[NUM_PLANES];
  assign out_req.visible     = !tok[NUM_PLANES].invalid && !tok[NUM_PLANES].culled;
  assign out_req.box_invalid = tok[NUM_PLANES].invalid;

  `AFCT_ASSERT_IMP(a_res_exclusive, clk, rst_n, out_valid,
                   !(out_req.visible && out_req.box_invalid))
  `AFCT_ASSERT_NXT(a_accept_fills, clk, rst_n, in_valid && !in_stall, s0_v_r)
  `AFCT_ASSERT_IMP(a_stall_when_full, clk, rst_n, in_stall, s0_v_r && !rdy[0])

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the AABB frustum cull test unit.
// Drives boxes through the valid/stall request channel and checks every
// visible / box_invalid result against an in-bench positive-vertex culling
// predictor. Planes are reloaded, between and within phases, while the unit is drained.
// Directed boxes cover corner cases; a random stream follows under three
// sender / receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_PLANES = 6;
  localparam int LATENCY    = 2 * NUM_PLANES + 1;
  localparam int QUIET_MAX  = 2000;   // cycles with no request moving on either side
  localparam logic signed [afct_pkg::NRM_W-1:0] ONE_Q14     = 16'sh4000;
  localparam logic signed [afct_pkg::NRM_W-1:0] NEG_ONE_Q14 = 16'shC000;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [afct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [afct_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  afct_pkg::box_req_t             in_req    = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  afct_pkg::cull_res_t            out_req;

  afct_pkg::plane_t    plane_model [afct_pkg::REG_COUNT];
  afct_pkg::cull_res_t expected_verdicts[$];
  int                  mismatch_count = 0;
  int                  quiet_cycles   = 0;
  int                  tx_idle_pct    = 22;
  int                  rx_idle_pct    = 61;

  aabb_frustum_cull_test_unit #(.NUM_PLANES(NUM_PLANES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------------
  // culling predictor
  // ------------------------------------------------------------------------
  function automatic afct_pkg::cull_res_t predict_cull(afct_pkg::box_req_t b);
    longint              lo[3];
    longint              hi[3];
    longint              nrm[3];
    longint              acc;
    afct_pkg::cull_res_t r;
    lo[0] = $signed(b.min_x); lo[1] = $signed(b.min_y); lo[2] = $signed(b.min_z);
    hi[0] = $signed(b.max_x); hi[1] = $signed(b.max_y); hi[2] = $signed(b.max_z);
    r.box_invalid = 1'b0;
    for (int a = 0; a < 3; a++)
      if (lo[a] > hi[a]) r.box_invalid = 1'b1;
    r.visible = ~r.box_invalid;
    if (!r.box_invalid) begin
      for (int p = 0; p < NUM_PLANES && p < afct_pkg::REG_COUNT; p++) begin
        nrm[0] = $signed(plane_model[p].nx);
        nrm[1] = $signed(plane_model[p].ny);
        nrm[2] = $signed(plane_model[p].nz);
        acc = longint'($signed(plane_model[p].d)) * (longint'(1) << afct_pkg::FRAC_BITS);
        // positive vertex: max corner where the normal is non-negative
        for (int a = 0; a < 3; a++)
          acc += nrm[a] * ((nrm[a] >= 0) ? hi[a] : lo[a]);
        if (acc < 0) r.visible = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic afct_pkg::box_req_t make_box(int mnx, int mny, int mnz,
                                                  int mxx, int mxy, int mxz);
    afct_pkg::box_req_t b;
    b.min_x = mnx[afct_pkg::COORD_W-1:0];
    b.min_y = mny[afct_pkg::COORD_W-1:0];
    b.min_z = mnz[afct_pkg::COORD_W-1:0];
    b.max_x = mxx[afct_pkg::COORD_W-1:0];
    b.max_y = mxy[afct_pkg::COORD_W-1:0];
    b.max_z = mxz[afct_pkg::COORD_W-1:0];
    return b;
  endfunction

  function automatic afct_pkg::plane_t make_plane(int nx, int ny, int nz, int d);
    afct_pkg::plane_t p;
    p.nx = nx[afct_pkg::NRM_W-1:0];
    p.ny = ny[afct_pkg::NRM_W-1:0];
    p.nz = nz[afct_pkg::NRM_W-1:0];
    p.d  = d[afct_pkg::DIST_W-1:0];
    return p;
  endfunction

  function automatic afct_pkg::box_req_t rand_box();
    logic signed [afct_pkg::COORD_W-1:0] pair [2];
    logic signed [afct_pkg::COORD_W-1:0] lo_c [3];
    logic signed [afct_pkg::COORD_W-1:0] hi_c [3];
    logic signed [afct_pkg::COORD_W-1:0] tmp;
    afct_pkg::box_req_t b;
    bit                 full;
    int                 kind;
    int                 ax;
    full = ($urandom_range(99) < 25);
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 2; k++)
        pair[k] = full ? afct_pkg::COORD_W'($urandom)
                       : afct_pkg::COORD_W'($urandom_range(600) - 300);
      lo_c[a] = (pair[0] > pair[1]) ? pair[1] : pair[0];
      hi_c[a] = (pair[0] > pair[1]) ? pair[0] : pair[1];
    end
    kind = $urandom_range(99);
    ax   = $urandom_range(2);
    if (kind < 8) begin
      // broken box: min above max on one axis
      if (lo_c[ax] == hi_c[ax]) begin
        if (hi_c[ax] == 16'sh7FFF) hi_c[ax] = hi_c[ax] - 16'sd1;
        else lo_c[ax] = lo_c[ax] + 16'sd1;
      end else begin
        tmp = lo_c[ax]; lo_c[ax] = hi_c[ax]; hi_c[ax] = tmp;
      end
    end else if (kind < 14) begin
      hi_c[ax] = lo_c[ax];
    end
    b.min_x = lo_c[0]; b.min_y = lo_c[1]; b.min_z = lo_c[2];
    b.max_x = hi_c[0]; b.max_y = hi_c[1]; b.max_z = hi_c[2];
    return b;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%t ERROR: %s", $realtime, msg);
  endfunction

  // ------------------------------------------------------------------------
  // driver tasks
  // ------------------------------------------------------------------------
  task automatic send_box(input afct_pkg::box_req_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      in_req   <= {$urandom, $urandom, $urandom};
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_verdicts.push_back(predict_cull(b));
  endtask

  // hold the sender until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_plane(input logic [afct_pkg::CFG_IDX_W-1:0] idx,
                             input afct_pkg::plane_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx < afct_pkg::REG_COUNT && idx < NUM_PLANES) plane_model[idx] = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_random_planes();
    afct_pkg::plane_t p;
    int               pick;
    int               active;
    int               half;
    int               ctr;
    drain_results();
    if ($urandom_range(2) == 0) begin
      // box-shaped frustum around a random center
      for (int a = 0; a < 3; a++) begin
        half = $urandom_range(2000, 20);
        ctr  = $urandom_range(1000) - 500;
        p = '0;
        p.d = afct_pkg::DIST_W'(half - ctr);
        if (a == 0) p.nx = ONE_Q14; else if (a == 1) p.ny = ONE_Q14; else p.nz = ONE_Q14;
        write_plane(afct_pkg::CFG_IDX_W'(2 * a), p);
        p = '0;
        p.d = afct_pkg::DIST_W'(half + ctr);
        if (a == 0) p.nx = NEG_ONE_Q14; else if (a == 1) p.ny = NEG_ONE_Q14;
        else p.nz = NEG_ONE_Q14;
        write_plane(afct_pkg::CFG_IDX_W'(2 * a + 1), p);
      end
    end else begin
      active = $urandom_range(afct_pkg::REG_COUNT);
      for (int i = 0; i < (1 << afct_pkg::CFG_IDX_W); i++) begin
        pick = $urandom_range(99);
        p = {$urandom, $urandom};
        if (i >= active || pick < 12) p = '0;
        else if (pick < 18) p = '1;
        else if (pick < 24) p = {4{16'h8000}};
        else if (pick < 30) p = {4{16'h7FFF}};
        else if (pick < 75) p.d = afct_pkg::DIST_W'($urandom_range(800) - 400);
        write_plane(afct_pkg::CFG_IDX_W'(i), p);
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  task automatic test_zero_planes();
    // planes are clear after reset, so only broken boxes fail
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(7, -7, 32767, 7, -7, 32767));
    send_box(make_box(1, 0, 0, 0, 0, 0));
    send_box(make_box(0, 32767, 0, 0, -32768, 0));
    send_box(make_box(0, 0, -5, 0, 0, -6));
    drain_results();
  endtask

  task automatic test_cube_frustum();
    // six planes bounding [-100, 100] on each axis
    write_plane(afct_pkg::REG_PLANE_0, make_plane(ONE_Q14, 0, 0, 100));
    write_plane(afct_pkg::REG_PLANE_1, make_plane(NEG_ONE_Q14, 0, 0, 100));
    write_plane(afct_pkg::REG_PLANE_2, make_plane(0, ONE_Q14, 0, 100));
    write_plane(afct_pkg::REG_PLANE_3, make_plane(0, NEG_ONE_Q14, 0, 100));
    write_plane(afct_pkg::REG_PLANE_4, make_plane(0, 0, ONE_Q14, 100));
    write_plane(afct_pkg::REG_PLANE_5, make_plane(0, 0, NEG_ONE_Q14, 100));
    send_box(make_box(-50, -50, -50, 50, 50, 50));
    send_box(make_box(-200, -200, -200, 200, 200, 200));
    send_box(make_box(150, 0, 0, 300, 10, 10));
    send_box(make_box(0, 0, -400, 10, 10, -101));
    // max corner exactly on the plane gives a zero sum: kept
    send_box(make_box(-300, 0, 0, -100, 10, 10));
    send_box(make_box(10, 0, 0, 5, 10, 10));
    drain_results();
  endtask

  task automatic test_extreme_planes();
    for (int i = 0; i < afct_pkg::REG_COUNT - 1; i++)
      write_plane(afct_pkg::CFG_IDX_W'(i), '0);
    write_plane(afct_pkg::REG_PLANE_5, make_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, 0, 0, 0));
    drain_results();
    // most negative normals pick the min corner
    write_plane(afct_pkg::REG_PLANE_5, make_plane(16'h8000, 16'h8000, 16'h8000, 16'h7FFF));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    drain_results();
  endtask

  task automatic test_ignored_index();
    write_plane(afct_pkg::REG_PLANE_5, '0);
    // indexes past the last plane must not land anywhere
    write_plane(afct_pkg::CFG_IDX_W'(afct_pkg::REG_COUNT), '1);
    write_plane(afct_pkg::CFG_IDX_W'(afct_pkg::REG_COUNT + 1),
                make_plane(0, 0, 0, 16'h8000));
    send_box(make_box(-10, -10, -10, 10, 10, 10));
    drain_results();
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, int count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 115 == 0) load_random_planes();
      else if ($urandom_range(149) == 0) drain_results();
      send_box(rand_box());
    end
    drain_results();
  endtask

  task automatic test_random_stream();
    run_phase(22, 61, 470);
    run_phase(61, 22, 470);
    run_phase(0, 0, 460);
  endtask

  // ------------------------------------------------------------------------
  // receiver, result checker, watchdog
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    afct_pkg::cull_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        note_mismatch($sformatf("result with no request pending: visible=%0b box_invalid=%0b",
                                out_req.visible, out_req.box_invalid));
      end else begin
        want = expected_verdicts.pop_front();
        if (out_req.visible !== want.visible)
          note_mismatch($sformatf("visible: expected %0b, got %0b",
                                  want.visible, out_req.visible));
        if (out_req.box_invalid !== want.box_invalid)
          note_mismatch($sformatf("box_invalid: expected %0b, got %0b",
                                  want.box_invalid, out_req.box_invalid));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < afct_pkg::REG_COUNT; i++) plane_model[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_planes();
    test_cube_frustum();
    test_extreme_planes();
    test_ignored_index();
    test_random_stream();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
